### design/i2cq_pkg.sv
// shared types, codes and default sizes of the i2c write-then-read transaction queue
package i2cq_pkg;

    // default sizes
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_WRITE   = 10;
    localparam int DEF_MAX_READ    = 128;

    // command codes
    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_STAGE  = 2'd1;
    localparam logic [1:0] CMD_EVENT  = 2'd2;

    // ack and interrupt enable control codes
    localparam logic [1:0] CTRL_KEEP  = 2'd0;
    localparam logic [1:0] CTRL_SET   = 2'd1;
    localparam logic [1:0] CTRL_CLEAR = 2'd2;

    // peripheral status flags of one event
    typedef struct packed {
        logic sb;
        logic addr;
        logic btf;
        logic txe;
        logic rxne;
    } status_t;

    // one result beat
    typedef struct packed {
        logic       dr_write_valid;
        logic [7:0] dr_value;
        logic       request_start;
        logic       request_stop;
        logic [1:0] ack_control;
        logic [1:0] buffer_irq_control;
        logic [1:0] event_irq_control;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       busy_res;
        logic       queue_full;
    } result_t;

    // state updates asked for by the event decision
    typedef struct packed {
        logic write_inc;
        logic read_inc;
        logic finish;
    } ev_step_t;

endpackage

### design/i2cq_ram.sv
// generic simple dual-port ram with registered read
module i2cq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/i2cq_decide.sv
// action decision for one status event of the running transaction
module i2cq_decide #(
    parameter int MAX_WRITE = i2cq_pkg::DEF_MAX_WRITE,
    parameter int MAX_READ  = i2cq_pkg::DEF_MAX_READ
) (
    input  i2cq_pkg::status_t                 status,
    input  logic [7:0]                        rx_byte,
    input  logic [7:0]                        tx_byte,
    input  logic [$clog2(MAX_WRITE+1)-1:0]    write_len,
    input  logic [$clog2(MAX_WRITE+1)-1:0]    write_index,
    input  logic [$clog2(MAX_READ+1)-1:0]     read_len,
    input  logic [$clog2(MAX_READ+1)-1:0]     read_index,
    input  logic [6:0]                        address,
    input  logic                              queue_nonempty,
    output i2cq_pkg::result_t                 res,
    output i2cq_pkg::ev_step_t                step
);

    import i2cq_pkg::*;

    localparam int WIW  = $clog2(MAX_WRITE + 1);
    localparam int WIW1 = WIW + 1;
    localparam int RLW  = $clog2(MAX_READ + 1);
    localparam int RLW1 = RLW + 1;

    logic [WIW1-1:0] wl_x;
    logic [WIW1-1:0] wi_x;
    logic [WIW1-1:0] wi1;
    logic [WIW1-1:0] wi2;
    logic [RLW1-1:0] rl_x;
    logic [RLW1-1:0] ri_x;
    logic [RLW1-1:0] ri1;
    logic [RLW1-1:0] ri2;

    assign wl_x = WIW1'(write_len);
    assign wi_x = WIW1'(write_index);
    assign wi1  = wi_x + WIW1'(1);
    assign wi2  = wi_x + WIW1'(2);
    assign rl_x = RLW1'(read_len);
    assign ri_x = RLW1'(read_index);
    assign ri1  = ri_x + RLW1'(1);
    assign ri2  = ri_x + RLW1'(2);

    always_comb
    begin
        res  = '0;
        step = '0;
        if (wi_x < wl_x)
        begin
            // write phase
            if (status.sb)
            begin
                res.dr_write_valid = 1'b1;
                res.dr_value       = {address, 1'b0};
            end
            else if (status.addr)
            begin
                if (wl_x > WIW1'(1))
                begin
                    res.buffer_irq_control = CTRL_SET;
                end
                res.dr_write_valid = 1'b1;
                res.dr_value       = tx_byte;
            end
            else if (status.btf && wi1 == wl_x)
            begin
                step.write_inc = 1'b1;
                if (rl_x == '0)
                begin
                    res.request_stop = 1'b1;
                    step.finish      = 1'b1;
                end
                else
                begin
                    res.request_start = 1'b1;
                end
            end
            else if (status.txe && wi1 < wl_x)
            begin
                step.write_inc = 1'b1;
                if (wi2 == wl_x)
                begin
                    res.buffer_irq_control = CTRL_CLEAR;
                end
                res.dr_write_valid = 1'b1;
                res.dr_value       = tx_byte;
            end
        end
        else if (ri_x < rl_x)
        begin
            // read phase
            if (status.sb)
            begin
                res.dr_write_valid = 1'b1;
                res.dr_value       = {address, 1'b1};
                res.ack_control    = (ri1 == rl_x) ? CTRL_CLEAR : CTRL_SET;
            end
            else if (status.addr)
            begin
                res.buffer_irq_control = CTRL_SET;
                if (rl_x == RLW1'(1))
                begin
                    res.request_stop = 1'b1;
                end
            end
            else if (status.rxne)
            begin
                res.read_valid = 1'b1;
                res.read_byte  = rx_byte;
                step.read_inc  = 1'b1;
                if (ri1 == rl_x)
                begin
                    res.buffer_irq_control = CTRL_CLEAR;
                    res.read_last          = 1'b1;
                    step.finish            = 1'b1;
                end
                else if (ri2 == rl_x)
                begin
                    res.ack_control  = CTRL_CLEAR;
                    res.request_stop = 1'b1;
                end
            end
        end

        // chain the next queued transaction or go idle
        if (step.finish)
        begin
            if (queue_nonempty)
            begin
                res.request_start = 1'b1;
            end
            else
            begin
                res.event_irq_control = CTRL_CLEAR;
            end
        end
    end

endmodule

### design/i2c_write_read_transaction_queue_unit.sv
// top level of the i2c write-then-read transaction queue
// submit, stage, no-op and dropped-submit beats give their result in the cycle after acceptance
// a status event of a running transaction reads the byte ram, then is decided in ST_EVENT
// a stored submit stalls input while the whole staging buffer is copied to the ring
// input also stalls while an event is decided and while the output beat is stalled
// reset: control state clears at once, idle and empty; header and byte rams are not cleared
module i2c_write_read_transaction_queue_unit #(
    parameter int QUEUE_DEPTH = i2cq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_WRITE   = i2cq_pkg::DEF_MAX_WRITE,
    parameter int MAX_READ    = i2cq_pkg::DEF_MAX_READ
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [3:0] write_len,
    input  logic [7:0] read_len,
    input  logic [6:0] target_address,
    input  logic [7:0] data_byte,
    input  logic       flag_start_sent,
    input  logic       flag_address_sent,
    input  logic       flag_transfer_done,
    input  logic       flag_tx_empty,
    input  logic       flag_rx_full,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       dr_write_valid,
    output logic [7:0] dr_value,
    output logic       request_start,
    output logic       request_stop,
    output logic [1:0] ack_control,
    output logic [1:0] buffer_irq_control,
    output logic [1:0] event_irq_control,
    output logic       read_valid,
    output logic [7:0] read_byte,
    output logic       read_last,
    output logic       busy_res,
    output logic       queue_full
);

    import i2cq_pkg::*;

    // derived widths
    localparam int QW   = $clog2(QUEUE_DEPTH);            // ring slot index and wait count
    localparam int QW1  = QW + 1;
    localparam int WIW  = $clog2(MAX_WRITE + 1);          // write length and index
    localparam int WIW1 = WIW + 1;
    localparam int SIW  = (MAX_WRITE > 1) ? $clog2(MAX_WRITE) : 1;  // staging position
    localparam int RLW  = $clog2(MAX_READ + 1);           // read length and index
    localparam int HW   = WIW + RLW + 7;                  // header: wlen, rlen, address
    localparam int BDEP = QUEUE_DEPTH * MAX_WRITE;        // byte ram depth
    localparam int BAW  = $clog2(BDEP);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_COPY  = 3'b010,
        ST_EVENT = 3'b100
    } state_t;

    // start of a slot's write bytes in the byte ram
    function automatic logic [BAW-1:0] slot_base(input logic [QW-1:0] s);
        return BAW'(s) * BAW'(MAX_WRITE);
    endfunction

    // control state
    state_t           state_reg,      state_next;
    logic             busy_reg,       busy_next;
    logic [QW-1:0]    qcount_reg,     qcount_next;
    logic [QW-1:0]    head_reg,       head_next;
    logic [WIW-1:0]   stage_cnt_reg,  stage_cnt_next;
    logic [WIW-1:0]   wi_reg,         wi_next;
    logic [RLW-1:0]   ri_reg,         ri_next;
    logic [SIW-1:0]   copy_idx_reg,   copy_idx_next;
    logic             out_valid_reg,  out_valid_next;

    // running transaction and staging payload
    logic [BAW-1:0]   cur_base_reg,   cur_base_next;
    logic [WIW-1:0]   cur_wlen_reg,   cur_wlen_next;
    logic [RLW-1:0]   cur_rlen_reg,   cur_rlen_next;
    logic [6:0]       cur_addr_reg,   cur_addr_next;
    logic [BAW-1:0]   copy_base_reg,  copy_base_next;
    status_t          ev_status_reg,  ev_status_next;
    logic [7:0]       ev_data_reg,    ev_data_next;
    result_t          out_res_reg,    out_res_next;
    logic [7:0]       staging_mem [MAX_WRITE];

    // combinational helpers
    logic             accept;
    logic             stage_we;
    logic [WIW-1:0]   wl_sat;
    logic [RLW-1:0]   rl_sat;
    logic [QW1-1:0]   slot_sum;
    logic [QW-1:0]    tail_slot;
    logic [QW-1:0]    head_inc;
    logic             q_full;
    logic             sub_empty;
    logic [WIW1-1:0]  wi1;
    logic [SIW-1:0]   byte_idx;
    status_t          status_in;

    // ram ports
    logic             hdr_we;
    logic [HW-1:0]    hdr_wdata;
    logic             hdr_re;
    logic [HW-1:0]    hdr_rdata;
    logic             byte_we;
    logic [BAW-1:0]   byte_waddr;
    logic             byte_re;
    logic [BAW-1:0]   byte_raddr;
    logic [7:0]       byte_rdata;

    // event decision
    result_t          dec_res;
    ev_step_t         dec_step;

    // handshake: one item at a time, output register frees itself while taken
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    // submit length saturation and empty check
    assign wl_sat    = (32'(write_len) > MAX_WRITE) ? WIW'(MAX_WRITE) : WIW'(write_len);
    assign rl_sat    = (32'(read_len) > MAX_READ) ? RLW'(MAX_READ) : RLW'(read_len);
    assign sub_empty = (wl_sat == '0) && (rl_sat == '0);

    // ring arithmetic; one slot always belongs to the running transaction
    assign slot_sum  = QW1'(head_reg) + QW1'(qcount_reg);
    assign tail_slot = (slot_sum >= QW1'(QUEUE_DEPTH)) ? QW'(slot_sum - QW1'(QUEUE_DEPTH))
                                                      : QW'(slot_sum);
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);
    assign q_full    = busy_reg && (qcount_reg == QW'(QUEUE_DEPTH - 1));

    assign status_in = '{sb:   flag_start_sent,
                         addr: flag_address_sent,
                         btf:  flag_transfer_done,
                         txe:  flag_tx_empty,
                         rxne: flag_rx_full};

    // header ram: written on every stored submit, read at the ring head on every event
    // so a chained transaction can load its header while the event is decided
    assign hdr_we    = accept && (command == CMD_SUBMIT) && !sub_empty && !q_full;
    assign hdr_wdata = {wl_sat, rl_sat, target_address};
    assign hdr_re    = accept && (command == CMD_EVENT);

    // byte fetch: address phase sends byte 0, tx empty sends the next one
    assign wi1      = WIW1'(wi_reg) + WIW1'(1);
    assign byte_idx = (flag_address_sent || (wi1 >= WIW1'(MAX_WRITE))) ? '0 : SIW'(wi1);
    assign byte_re    = hdr_re;
    assign byte_raddr = cur_base_reg + BAW'(byte_idx);

    // staging copy into the ring slot, one byte per cycle
    assign byte_we    = (state_reg == ST_COPY);
    assign byte_waddr = copy_base_reg + BAW'(copy_idx_reg);

    i2cq_ram #(
        .WIDTH (HW),
        .DEPTH (QUEUE_DEPTH)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (hdr_we),
        .wr_addr (tail_slot),
        .wr_data (hdr_wdata),
        .rd_en   (hdr_re),
        .rd_addr (head_reg),
        .rd_data (hdr_rdata)
    );

    i2cq_ram #(
        .WIDTH (8),
        .DEPTH (BDEP)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_we),
        .wr_addr (byte_waddr),
        .wr_data (staging_mem[copy_idx_reg]),
        .rd_en   (byte_re),
        .rd_addr (byte_raddr),
        .rd_data (byte_rdata)
    );

    i2cq_decide #(
        .MAX_WRITE (MAX_WRITE),
        .MAX_READ  (MAX_READ)
    ) u_decide (
        .status         (ev_status_reg),
        .rx_byte        (ev_data_reg),
        .tx_byte        (byte_rdata),
        .write_len      (cur_wlen_reg),
        .write_index    (wi_reg),
        .read_len       (cur_rlen_reg),
        .read_index     (ri_reg),
        .address        (cur_addr_reg),
        .queue_nonempty (qcount_reg != '0),
        .res            (dec_res),
        .step           (dec_step)
    );

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        qcount_next    = qcount_reg;
        head_next      = head_reg;
        stage_cnt_next = stage_cnt_reg;
        wi_next        = wi_reg;
        ri_next        = ri_reg;
        copy_idx_next  = copy_idx_reg;
        cur_base_next  = cur_base_reg;
        cur_wlen_next  = cur_wlen_reg;
        cur_rlen_next  = cur_rlen_reg;
        cur_addr_next  = cur_addr_reg;
        copy_base_next = copy_base_reg;
        ev_status_next = ev_status_reg;
        ev_data_next   = ev_data_reg;
        out_res_next   = out_res_reg;
        stage_we       = 1'b0;

        // output beat taken
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_res_next          = '0;
                    out_res_next.busy_res = busy_reg;
                    case (command)
                        CMD_SUBMIT:
                        begin
                            stage_cnt_next = '0;
                            out_valid_next = 1'b1;
                            if (sub_empty)
                            begin
                                // nothing to do
                            end
                            else if (q_full)
                            begin
                                out_res_next.queue_full = 1'b1;
                            end
                            else
                            begin
                                copy_idx_next  = '0;
                                copy_base_next = slot_base(tail_slot);
                                state_next     = ST_COPY;
                                if (busy_reg)
                                begin
                                    qcount_next = qcount_reg + QW'(1);
                                end
                                else
                                begin
                                    // start at once
                                    head_next     = head_inc;
                                    cur_base_next = slot_base(tail_slot);
                                    cur_wlen_next = wl_sat;
                                    cur_rlen_next = rl_sat;
                                    cur_addr_next = target_address;
                                    wi_next       = '0;
                                    ri_next       = '0;
                                    busy_next     = 1'b1;
                                    out_res_next.request_start     = 1'b1;
                                    out_res_next.event_irq_control = CTRL_SET;
                                    out_res_next.busy_res          = 1'b1;
                                end
                            end
                        end
                        CMD_STAGE:
                        begin
                            out_valid_next = 1'b1;
                            if (stage_cnt_reg < WIW'(MAX_WRITE))
                            begin
                                stage_we       = 1'b1;
                                stage_cnt_next = stage_cnt_reg + WIW'(1);
                            end
                        end
                        CMD_EVENT:
                        begin
                            if (busy_reg)
                            begin
                                ev_status_next = status_in;
                                ev_data_next   = data_byte;
                                state_next     = ST_EVENT;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (copy_idx_reg == SIW'(MAX_WRITE - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    copy_idx_next = copy_idx_reg + SIW'(1);
                end
            end
            ST_EVENT:
            begin
                out_res_next   = dec_res;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (dec_step.write_inc)
                begin
                    wi_next = wi_reg + WIW'(1);
                end
                if (dec_step.read_inc)
                begin
                    ri_next = ri_reg + RLW'(1);
                end
                if (dec_step.finish)
                begin
                    if (qcount_reg != '0)
                    begin
                        // chain the transaction at the ring head
                        cur_base_next = slot_base(head_reg);
                        {cur_wlen_next, cur_rlen_next, cur_addr_next} = hdr_rdata;
                        head_next     = head_inc;
                        qcount_next   = qcount_reg - QW'(1);
                        wi_next       = '0;
                        ri_next       = '0;
                        busy_next     = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                out_res_next.busy_res = busy_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            qcount_reg    <= '0;
            head_reg      <= '0;
            stage_cnt_reg <= '0;
            wi_reg        <= '0;
            ri_reg        <= '0;
            copy_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            cur_base_reg  <= '0;
            cur_wlen_reg  <= '0;
            cur_rlen_reg  <= '0;
            cur_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            qcount_reg    <= qcount_next;
            head_reg      <= head_next;
            stage_cnt_reg <= stage_cnt_next;
            wi_reg        <= wi_next;
            ri_reg        <= ri_next;
            copy_idx_reg  <= copy_idx_next;
            out_valid_reg <= out_valid_next;
            cur_base_reg  <= cur_base_next;
            cur_wlen_reg  <= cur_wlen_next;
            cur_rlen_reg  <= cur_rlen_next;
            cur_addr_reg  <= cur_addr_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        copy_base_reg <= copy_base_next;
        ev_status_reg <= ev_status_next;
        ev_data_reg   <= ev_data_next;
        out_res_reg   <= out_res_next;
        if (stage_we)
        begin
            staging_mem[stage_cnt_reg[SIW-1:0]] <= data_byte;
        end
    end

    // output fields
    assign dr_write_valid     = out_res_reg.dr_write_valid;
    assign dr_value           = out_res_reg.dr_value;
    assign request_start      = out_res_reg.request_start;
    assign request_stop       = out_res_reg.request_stop;
    assign ack_control        = out_res_reg.ack_control;
    assign buffer_irq_control = out_res_reg.buffer_irq_control;
    assign event_irq_control  = out_res_reg.event_irq_control;
    assign read_valid         = out_res_reg.read_valid;
    assign read_byte          = out_res_reg.read_byte;
    assign read_last          = out_res_reg.read_last;
    assign busy_res           = out_res_reg.busy_res;
    assign queue_full         = out_res_reg.queue_full;

`ifndef SYNTHESIS
    // nothing waits in the ring while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (qcount_reg == '0))
        else $error("transactions queued while idle");

    // at most QUEUE_DEPTH-1 transactions wait
    assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg <= QW'(QUEUE_DEPTH - 1))
        else $error("ring wait count overflow");

    // indexes never run past the running transaction's lengths
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((wi_reg <= cur_wlen_reg) && (ri_reg <= cur_rlen_reg)))
        else $error("transfer index past its length");

    // an event of a running transaction gives its beat once ST_EVENT has decided it
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_EVENT) && busy_reg) |=> ##1 out_valid_reg)
        else $error("event beat missing");

    // a last mark only comes with a delivered byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.read_last) |-> out_res_reg.read_valid)
        else $error("read_last without read_valid");
`endif

endmodule
